// ===== rtl/rtff_pkg.sv =====
`default_nettype none
package rtff_pkg;

   localparam logic [7:0] PREAMBLE = 8'hD3;

   localparam int SLOT_REGS            = 5;
   localparam int NUM_WANTED_TYPES_DEF = 5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_WANTED_TYPE_A   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WANTED_TYPE_B   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WANTED_TYPE_C   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WANTED_TYPE_D   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_WANTED_TYPE_E   = 3'd5;

   localparam logic [9:0]  MAX_PAYLOAD_LEN_RST = 10'd1023;
   localparam logic [11:0] WANTED_TYPE_A_RST   = 12'd1005;
   localparam logic [11:0] WANTED_TYPE_B_RST   = 12'd1074;
   localparam logic [11:0] WANTED_TYPE_C_RST   = 12'd1084;
   localparam logic [11:0] WANTED_TYPE_D_RST   = 12'd1094;
   localparam logic [11:0] WANTED_TYPE_E_RST   = 12'd1230;

   typedef logic [SLOT_REGS-1:0][11:0] wanted_types_type;

   typedef struct packed {
      logic [10:0] frame_len;
      logic [11:0] msg_type;
   } frame_rec_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [SLOT_REGS-1:0] seen;
      logic                 pop;
   } back_status_type;

endpackage
`default_nettype wire

// ===== rtl/rtcm3_frame_type_filter_top.sv =====
`default_nettype none
// channel   dir   transfer                     payload
// req_      in    req_tvalid & req_tready      rx_byte
// rsp_      out   rsp_tvalid & rsp_tready      msg_type, frame_len, forward_frame,
//                                              seen_mask, all_seen
// csr_      in    psel & penable & pwrite      six registers at 4*i
//
// one byte a cycle while req_tready is high; the parser steps once per byte transfer
// a frame result reaches rsp_ after its last byte through the queue, then the output register
// a four-entry result queue parts the parser from the output side; req_tready
// drops only when it is full
// synchronous active-high reset; reset brings back register defaults and clears the seen mask
module rtcm3_frame_type_filter_top #(
   parameter int NUM_WANTED_TYPES = rtff_pkg::NUM_WANTED_TYPES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] rx_byte
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [11:0] msg_type, [22:12] frame_len, [23] forward_frame,
   // [28:24] seen_mask, [29] all_seen
   output      logic [31:0]                     rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rtff_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rtff_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [rtff_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready
);

   logic [9:0]                     max_len_ff;
   rtff_pkg::wanted_types_type     wanted_ff;
   logic [rtff_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           csr_wr;
   logic                           byte_valid;
   logic                           push;
   rtff_pkg::frame_rec_type        push_rec;
   rtff_pkg::frame_rec_type        head_rec;
   rtff_pkg::queue_status_type     q_status;
   rtff_pkg::back_status_type      b_status;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[rtff_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= rtff_pkg::MAX_PAYLOAD_LEN_RST;
         wanted_ff[0] <= rtff_pkg::WANTED_TYPE_A_RST;
         wanted_ff[1] <= rtff_pkg::WANTED_TYPE_B_RST;
         wanted_ff[2] <= rtff_pkg::WANTED_TYPE_C_RST;
         wanted_ff[3] <= rtff_pkg::WANTED_TYPE_D_RST;
         wanted_ff[4] <= rtff_pkg::WANTED_TYPE_E_RST;
      end else if (csr_wr) begin
         case (reg_idx)
            rtff_pkg::REG_MAX_PAYLOAD_LEN: max_len_ff   <= csr_pwdata[9:0];
            rtff_pkg::REG_WANTED_TYPE_A:   wanted_ff[0] <= csr_pwdata[11:0];
            rtff_pkg::REG_WANTED_TYPE_B:   wanted_ff[1] <= csr_pwdata[11:0];
            rtff_pkg::REG_WANTED_TYPE_C:   wanted_ff[2] <= csr_pwdata[11:0];
            rtff_pkg::REG_WANTED_TYPE_D:   wanted_ff[3] <= csr_pwdata[11:0];
            rtff_pkg::REG_WANTED_TYPE_E:   wanted_ff[4] <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rtff_pkg::REG_MAX_PAYLOAD_LEN: csr_prdata = {22'd0, max_len_ff};
         rtff_pkg::REG_WANTED_TYPE_A:   csr_prdata = {20'd0, wanted_ff[0]};
         rtff_pkg::REG_WANTED_TYPE_B:   csr_prdata = {20'd0, wanted_ff[1]};
         rtff_pkg::REG_WANTED_TYPE_C:   csr_prdata = {20'd0, wanted_ff[2]};
         rtff_pkg::REG_WANTED_TYPE_D:   csr_prdata = {20'd0, wanted_ff[3]};
         rtff_pkg::REG_WANTED_TYPE_E:   csr_prdata = {20'd0, wanted_ff[4]};
         default:                       csr_prdata = '0;
      endcase
   end

   assign req_tready = !q_status.full;
   assign byte_valid = req_tvalid && req_tready;

   rtff_front u_front (
      .clock           (clock),
      .reset           (reset),
      .byte_valid      (byte_valid),
      .rx_byte         (req_tdata),
      .max_payload_len (max_len_ff),
      .push            (push),
      .push_rec        (push_rec)
   );

   rtff_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (b_status.pop),
      .head_rec (head_rec),
      .status   (q_status)
   );

   rtff_back #(
      .NUM_WANTED_TYPES (NUM_WANTED_TYPES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_rec     (head_rec),
      .head_valid   (!q_status.empty),
      .wanted_types (wanted_ff),
      .status       (b_status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full && !b_status.pop))
      else $error("result queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      b_status.pop |-> !q_status.empty)
      else $error("pop from empty result queue");

   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(b_status.seen) & ~b_status.seen) == '0))
      else $error("seen mask lost a bit");

   a_forward_seen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[23]) |-> (rsp_tdata[28:24] != '0))
      else $error("forwarded frame with empty seen mask");

endmodule
`default_nettype wire

// ===== rtl/rtff_front.sv =====
`default_nettype none
module rtff_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_valid,
   input  wire logic [7:0]             rx_byte,
   input  wire logic [9:0]             max_payload_len,
   output      logic                   push,
   output      rtff_pkg::frame_rec_type push_rec
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [10:0] bytes_left_ff, bytes_left_in;
   logic [10:0] byte_count_ff, byte_count_in;
   logic [7:0]  type_high_ff, type_high_in;
   logic [3:0]  type_low_ff, type_low_in;
   logic [5:0]  len_high_ff, len_high_in;
   logic [13:0] len;

   assign len = {len_high_ff, rx_byte};

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      byte_count_in = byte_count_ff;
      type_high_in  = type_high_ff;
      type_low_in   = type_low_ff;
      len_high_in   = len_high_ff;
      push          = 1'b0;
      push_rec.msg_type  = {type_high_ff, type_low_ff};
      push_rec.frame_len = byte_count_ff + 11'd1;
      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == rtff_pkg::PREAMBLE) begin
                  byte_count_in = 11'd1;
                  phase_in      = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               len_high_in   = rx_byte[5:0];
               byte_count_in = 11'd2;
               phase_in      = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               byte_count_in = 11'd3;
               if (len > {4'd0, max_payload_len}) begin
                  phase_in = PH_HUNT;
               end else begin
                  bytes_left_in = {1'b0, len[9:0]} + 11'd3;
                  phase_in      = PH_BODY;
               end
            end
            PH_BODY: begin
               if (byte_count_ff == 11'd3) type_high_in = rx_byte;
               if (byte_count_ff == 11'd4) type_low_in = rx_byte[7:4];
               byte_count_in = byte_count_ff + 11'd1;
               bytes_left_in = bytes_left_ff - 11'd1;
               if (bytes_left_ff == 11'd1) begin
                  push          = 1'b1;
                  phase_in      = PH_HUNT;
                  bytes_left_in = 11'd0;
                  byte_count_in = 11'd0;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= 11'd0;
         byte_count_ff <= 11'd0;
         type_high_ff  <= 8'd0;
         type_low_ff   <= 4'd0;
         len_high_ff   <= 6'd0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         byte_count_ff <= byte_count_in;
         type_high_ff  <= type_high_in;
         type_low_ff   <= type_low_in;
         len_high_ff   <= len_high_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rtff_queue.sv =====
`default_nettype none
module rtff_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire rtff_pkg::frame_rec_type  push_rec,
   input  wire logic                     pop,
   output      rtff_pkg::frame_rec_type  head_rec,
   output      rtff_pkg::queue_status_type status
);

   rtff_pkg::frame_rec_type entry_ff [rtff_pkg::QUEUE_DEPTH];

   logic [rtff_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rtff_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rtff_pkg::QCNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == rtff_pkg::QCNT_W'(rtff_pkg::QUEUE_DEPTH));
   assign head_rec     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rtff_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + rtff_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + rtff_pkg::QCNT_W'(1);
      if (pop && !push) count_in = count_ff - rtff_pkg::QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rtff_back.sv =====
`default_nettype none
module rtff_back #(
   parameter int NUM_WANTED_TYPES = rtff_pkg::NUM_WANTED_TYPES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rtff_pkg::frame_rec_type    head_rec,
   input  wire logic                       head_valid,
   input  wire rtff_pkg::wanted_types_type wanted_types,
   output      rtff_pkg::back_status_type  status,
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [31:0]                rsp_tdata
);

   localparam int ActiveSlots = (NUM_WANTED_TYPES > rtff_pkg::SLOT_REGS) ? rtff_pkg::SLOT_REGS :
                                (NUM_WANTED_TYPES < 0) ? 0 : NUM_WANTED_TYPES;

   logic [rtff_pkg::SLOT_REGS-1:0] full_mask;
   logic [rtff_pkg::SLOT_REGS-1:0] match;
   logic [rtff_pkg::SLOT_REGS-1:0] seen_ff, seen_in;
   logic                           out_valid_ff, out_valid_in;
   logic [31:0]                    out_data_ff, out_data_in;
   logic                           pop;
   logic                           all_seen;

   always_comb begin
      for (int i = 0; i < rtff_pkg::SLOT_REGS; i++) begin
         full_mask[i] = (i < ActiveSlots);
         match[i]     = full_mask[i] && (head_rec.msg_type == wanted_types[i]);
      end
   end

   assign pop      = head_valid && (!out_valid_ff || rsp_tready);
   assign seen_in  = pop ? (seen_ff | match) : seen_ff;
   assign all_seen = ((seen_in & full_mask) == full_mask);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         out_data_in  = {2'b00, all_seen, seen_in, |match, head_rec.frame_len,
                         head_rec.msg_type};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_data_ff;
   assign status.seen = seen_ff;
   assign status.pop  = pop;

endmodule
`default_nettype wire

// ===== tb/rtff_checker.sv =====
`timescale 1ns / 1ps
module rtff_checker #(
   parameter int NUM_WANTED_TYPES = rtff_pkg::NUM_WANTED_TYPES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [rtff_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rtff_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               frames_pending,
   output logic             parser_hunting
);

   localparam int ACTIVE_SLOTS = (NUM_WANTED_TYPES < 0) ? 0 :
                                 (NUM_WANTED_TYPES > rtff_pkg::SLOT_REGS) ?
                                 rtff_pkg::SLOT_REGS : NUM_WANTED_TYPES;

   typedef enum logic [1:0] {
      HUNT_PREAMBLE,
      LEN_FIRST_BYTE,
      LEN_SECOND_BYTE,
      COUNT_BODY
   } parse_phase_type;

   typedef struct packed {
      logic [11:0] msg_type;
      logic [10:0] frame_len;
      logic        forward_frame;
      logic [4:0]  seen_mask;
      logic        all_seen;
   } frame_summary_type;

   frame_summary_type expected_frames[$];

   logic [9:0]      max_len;
   logic [11:0]     wanted_type[rtff_pkg::SLOT_REGS];
   parse_phase_type phase;
   logic [10:0]     bytes_left;
   logic [10:0]     byte_count;
   logic [7:0]      type_hi;
   logic [3:0]      type_lo;
   logic [5:0]      len_hi;
   logic [4:0]      seen_flags;

   initial begin
      fail_count = 0;
      frames_pending = 0;
      parser_hunting = 1'b1;
   end

   task report_mismatch(input string what, input int got, input int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   function void write_register(input logic [rtff_pkg::REG_IDX_W-1:0] idx,
                                input logic [31:0] value);
      if (idx == rtff_pkg::REG_MAX_PAYLOAD_LEN) begin
         max_len = value[9:0];
      end else if (idx >= rtff_pkg::REG_WANTED_TYPE_A &&
                   idx <= rtff_pkg::REG_WANTED_TYPE_E) begin
         wanted_type[idx - rtff_pkg::REG_WANTED_TYPE_A] = value[11:0];
      end
   endfunction

   function void parse_byte(input logic [7:0] b);
      logic [13:0]       len;
      logic [4:0]        full;
      frame_summary_type fs;
      case (phase)
         HUNT_PREAMBLE: begin
            if (b == rtff_pkg::PREAMBLE) begin
               byte_count = 11'd1;
               phase = LEN_FIRST_BYTE;
            end
         end
         LEN_FIRST_BYTE: begin
            len_hi = b[5:0];
            byte_count = 11'd2;
            phase = LEN_SECOND_BYTE;
         end
         LEN_SECOND_BYTE: begin
            len = {len_hi, b};
            byte_count = 11'd3;
            if (len > {4'd0, max_len}) begin
               phase = HUNT_PREAMBLE;
            end else begin
               bytes_left = 11'(len + 14'd3);
               phase = COUNT_BODY;
            end
         end
         default: begin
            if (byte_count == 11'd3) type_hi = b;
            if (byte_count == 11'd4) type_lo = b[7:4];
            byte_count = byte_count + 11'd1;
            bytes_left = bytes_left - 11'd1;
            if (bytes_left == 11'd0) begin
               fs.msg_type = {type_hi, type_lo};
               fs.forward_frame = 1'b0;
               full = '0;
               for (int i = 0; i < ACTIVE_SLOTS; i++) begin
                  full[i] = 1'b1;
                  if (fs.msg_type == wanted_type[i]) begin
                     fs.forward_frame = 1'b1;
                     seen_flags[i] = 1'b1;
                  end
               end
               fs.frame_len = byte_count;
               fs.seen_mask = seen_flags;
               fs.all_seen = ((seen_flags & full) == full);
               expected_frames.push_back(fs);
               phase = HUNT_PREAMBLE;
               bytes_left = '0;
               byte_count = '0;
            end
         end
      endcase
   endfunction

   task check_frame(input logic [31:0] d);
      frame_summary_type want;
      if (expected_frames.size() == 0) begin
         report_mismatch("frame result with none pending, msg_type", d[11:0], 0);
      end else begin
         want = expected_frames.pop_front();
         if (d[11:0] != want.msg_type)
            report_mismatch("msg_type", d[11:0], want.msg_type);
         if (d[22:12] != want.frame_len)
            report_mismatch("frame_len", d[22:12], want.frame_len);
         if (d[23] != want.forward_frame)
            report_mismatch("forward_frame", d[23], want.forward_frame);
         if (d[28:24] != want.seen_mask)
            report_mismatch("seen_mask", d[28:24], want.seen_mask);
         if (d[29] != want.all_seen)
            report_mismatch("all_seen", d[29], want.all_seen);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         max_len = rtff_pkg::MAX_PAYLOAD_LEN_RST;
         wanted_type[0] = rtff_pkg::WANTED_TYPE_A_RST;
         wanted_type[1] = rtff_pkg::WANTED_TYPE_B_RST;
         wanted_type[2] = rtff_pkg::WANTED_TYPE_C_RST;
         wanted_type[3] = rtff_pkg::WANTED_TYPE_D_RST;
         wanted_type[4] = rtff_pkg::WANTED_TYPE_E_RST;
         phase = HUNT_PREAMBLE;
         bytes_left = '0;
         byte_count = '0;
         type_hi = '0;
         type_lo = '0;
         len_hi = '0;
         seen_flags = '0;
         expected_frames.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_register(csr_paddr[4:2], csr_pwdata);
         if (req_tvalid && req_tready)
            parse_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_frame(rsp_tdata);
      end
      frames_pending = expected_frames.size();
      parser_hunting = (phase == HUNT_PREAMBLE);
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [rtff_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [rtff_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [rtff_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rtff_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rtff_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          frames_pending;
   logic        parser_hunting;
   int          cycle_count = 0;
   int          send_idle = 32;
   int          recv_idle = 56;
   int          bytes_sent = 0;
   logic [9:0]  cur_max;
   logic [11:0] cur_wanted[rtff_pkg::SLOT_REGS];

   rtcm3_frame_type_filter_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   rtff_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .frames_pending(frames_pending),
      .parser_hunting(parser_hunting)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   task send_byte(input logic [7:0] b);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait for every outstanding frame result
   task hold_off;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (frames_pending != 0) @(negedge clock);
   endtask

   task csr_write(input logic [rtff_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      if (idx == rtff_pkg::REG_MAX_PAYLOAD_LEN)
         cur_max = value[9:0];
      else if (idx >= rtff_pkg::REG_WANTED_TYPE_A && idx <= rtff_pkg::REG_WANTED_TYPE_E)
         cur_wanted[idx - rtff_pkg::REG_WANTED_TYPE_A] = value[11:0];
   endtask

   // bring the parser back to hunting with nothing in flight
   task settle;
      while (!parser_hunting) send_byte(8'h00);
      hold_off();
      repeat (8) @(negedge clock);
   endtask

   task set_registers(input logic [9:0] mx, input logic [11:0] a, input logic [11:0] b,
                      input logic [11:0] c, input logic [11:0] d, input logic [11:0] e);
      settle();
      csr_write(rtff_pkg::REG_MAX_PAYLOAD_LEN, 32'(mx));
      csr_write(rtff_pkg::REG_WANTED_TYPE_A, 32'(a));
      csr_write(rtff_pkg::REG_WANTED_TYPE_B, 32'(b));
      csr_write(rtff_pkg::REG_WANTED_TYPE_C, 32'(c));
      csr_write(rtff_pkg::REG_WANTED_TYPE_D, 32'(d));
      csr_write(rtff_pkg::REG_WANTED_TYPE_E, 32'(e));
   endtask

   task send_frame(input logic [13:0] len_field, input logic [1:0] rsv, input logic [11:0] mtype);
      int body;
      send_byte(rtff_pkg::PREAMBLE);
      send_byte({rsv, len_field[13:8]});
      send_byte(len_field[7:0]);
      if (len_field <= {4'd0, cur_max}) begin
         body = int'(len_field) + 3;
         for (int i = 0; i < body; i++) begin
            if (i == 0)
               send_byte(mtype[11:4]);
            else if (i == 1)
               send_byte({mtype[3:0], 4'($urandom_range(15))});
            else
               send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   function logic [11:0] pick_type;
      if ($urandom_range(99) < 60)
         return cur_wanted[$urandom_range(rtff_pkg::SLOT_REGS - 1)];
      return 12'($urandom_range(4095));
   endfunction

   task run_random(input int nbytes);
      int stop_at;
      int pick;
      int lim;
      stop_at = bytes_sent + nbytes;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         lim = (cur_max < 10'd12) ? int'(cur_max) + 2 : 14;
         if (pick < 75) begin
            send_frame(14'($urandom_range(lim)), 2'($urandom_range(3)), pick_type());
         end else if (pick < 82) begin
            // length beyond the 10-bit range
            send_frame(14'($urandom_range(16383, 1024)), 2'($urandom_range(3)), pick_type());
         end else if (pick < 90) begin
            // truncated header
            send_byte(rtff_pkg::PREAMBLE);
            if ($urandom_range(1)) send_byte(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end
         if ($urandom_range(24) == 0) hold_off();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cur_max = rtff_pkg::MAX_PAYLOAD_LEN_RST;
      cur_wanted[0] = rtff_pkg::WANTED_TYPE_A_RST;
      cur_wanted[1] = rtff_pkg::WANTED_TYPE_B_RST;
      cur_wanted[2] = rtff_pkg::WANTED_TYPE_C_RST;
      cur_wanted[3] = rtff_pkg::WANTED_TYPE_D_RST;
      cur_wanted[4] = rtff_pkg::WANTED_TYPE_E_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // noise while hunting, then the reset types one by one
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(14'd0, 2'b11, rtff_pkg::WANTED_TYPE_A_RST);
      send_frame(14'd1, 2'b00, 12'd0);
      send_frame(14'd2, 2'b10, 12'd4095);
      send_frame(14'd3, 2'b01, rtff_pkg::WANTED_TYPE_B_RST);
      send_frame(14'd4, 2'b00, rtff_pkg::WANTED_TYPE_C_RST);
      send_frame(14'd5, 2'b00, rtff_pkg::WANTED_TYPE_D_RST);
      // preambles inside the body do not resync
      send_byte(rtff_pkg::PREAMBLE);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(rtff_pkg::WANTED_TYPE_E_RST[11:4]);
      send_byte({rtff_pkg::WANTED_TYPE_E_RST[3:0], 4'h0});
      send_byte(rtff_pkg::PREAMBLE);
      send_byte(rtff_pkg::PREAMBLE);
      send_byte(rtff_pkg::PREAMBLE);
      // length 1024 dropped, then a hunted byte
      send_byte(rtff_pkg::PREAMBLE);
      send_byte(8'h04);
      send_byte(8'h00);
      send_byte(8'h00);
      send_frame(14'd40, 2'b00, pick_type());

      set_registers(10'd0, 12'd0, 12'd4095, 12'd4095, 12'd1005, 12'd2048);
      csr_write(REG_SPARE_LO, $urandom);
      csr_write(REG_SPARE_HI, $urandom);
      send_frame(14'd1, 2'b00, 12'd0);
      send_frame(14'd0, 2'b01, 12'd4095);
      send_frame(14'd0, 2'b00, 12'd2048);

      set_registers(10'd12, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                    12'($urandom_range(4095)), 12'd1074, 12'd1074);
      run_random(140);

      send_idle = 56;
      recv_idle = 32;
      set_registers(10'd1023, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'($urandom_range(4095)));
      run_random(140);

      send_idle = 0;
      recv_idle = 0;
      set_registers(10'd5, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                    12'($urandom_range(4095)), 12'($urandom_range(4095)),
                    12'($urandom_range(4095)));
      run_random(140);

      hold_off();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
